### rtl/core/hsvsc_pkg.sv
// Shared types, widths, register codes and reset values for the HSV shadow classifier.
// Used by hsvsc_band_check and hsv_shadow_pixel_classifier; depends on nothing.
`default_nettype none

package hsvsc_pkg;

	// Default fixed-point formats
	localparam int RATIO_FRAC_BITS_DEF  = 8;
	localparam int MARGIN_FRAC_BITS_DEF = 12;

	// Field and register widths
	localparam int CH_W          = 8;
	localparam int RATIO_LIMIT_W = 16;
	localparam int DIFF_LIMIT_W  = 8;
	localparam int MARGIN_W      = 13;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 3;

	// Register indexes on the write port
	localparam logic [CFG_INDEX_W-1:0] REG_RATIO_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RATIO_HIGH    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAT_LIMIT     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_LIMIT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_MARGIN = 3'd4;

	// Reset values
	localparam logic [RATIO_LIMIT_W-1:0] RATIO_LOW_RST     = 16'd0;
	localparam logic [RATIO_LIMIT_W-1:0] RATIO_HIGH_RST    = 16'd256;
	localparam logic [DIFF_LIMIT_W-1:0]  SAT_LIMIT_RST     = 8'd50;
	localparam logic [DIFF_LIMIT_W-1:0]  HUE_LIMIT_RST     = 8'd50;
	localparam logic [MARGIN_W-1:0]      CHANGE_MARGIN_RST = 13'd205;

	typedef struct packed {
		logic            foreground_bit;
		logic [CH_W-1:0] pixel_hue;
		logic [CH_W-1:0] pixel_saturation;
		logic [CH_W-1:0] pixel_value;
		logic [CH_W-1:0] back_hue;
		logic [CH_W-1:0] back_saturation;
		logic [CH_W-1:0] back_value;
	} pixel_t;

	typedef struct packed {
		logic shadow_flag;
		logic changed_flag;
	} result_t;

	// A zero channel enters a ratio as one
	function automatic logic [CH_W-1:0] nz(input logic [CH_W-1:0] x);
		return (x == '0) ? CH_W'(1) : x;
	endfunction

	function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
	                                             input logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

### rtl/core/hsvsc_band_check.sv
// Tests whether num/den lies strictly outside [1-m, 1+m] by cross-multiplication.
// One register stage holds the products; depends on hsvsc_pkg.
`default_nettype none

module hsvsc_band_check #(
	parameter int MARGIN_FRAC_BITS = hsvsc_pkg::MARGIN_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic [hsvsc_pkg::CH_W-1:0]     num,
	input  wire logic [hsvsc_pkg::CH_W-1:0]     den,
	input  wire logic [hsvsc_pkg::MARGIN_W-1:0] margin,
	output logic                                outside
);

	localparam int ONE_W  = MARGIN_FRAC_BITS + 1;
	localparam int FACT_W = ((ONE_W > hsvsc_pkg::MARGIN_W) ? ONE_W : hsvsc_pkg::MARGIN_W) + 1;
	localparam int PROD_W = hsvsc_pkg::CH_W + FACT_W;

	logic [FACT_W-1:0] one_f;
	logic [FACT_W-1:0] margin_f;
	logic [FACT_W-1:0] hi_fact;
	logic [FACT_W-1:0] lo_fact;

	logic [PROD_W-1:0] num_s2;
	logic [PROD_W-1:0] hi_s2;
	logic [PROD_W-1:0] lo_s2;

	always_comb begin
		one_f    = FACT_W'(1) << MARGIN_FRAC_BITS;
		margin_f = FACT_W'(margin);
		hi_fact  = one_f + margin_f;
		// margin of one or more: lower bound at or below zero, nothing falls under it
		lo_fact  = (margin_f >= one_f) ? '0 : (one_f - margin_f);
	end

	always_ff @(posedge clk) begin
		num_s2 <= PROD_W'(num) << MARGIN_FRAC_BITS;
		hi_s2  <= PROD_W'(den) * PROD_W'(hi_fact);
		lo_s2  <= PROD_W'(den) * PROD_W'(lo_fact);
	end

	assign outside = (num_s2 > hi_s2) || (num_s2 < lo_s2);

endmodule

`default_nettype wire

### rtl/core/hsv_shadow_pixel_classifier.sv
// Per-pixel HSV shadow and change classifier, top level.
// Depends on hsvsc_pkg and hsvsc_band_check.
// An accepted transaction passes the stage-1, stage-2 and result registers, then
// shows its result with strobe high. Throughput: one pixel per clock, busy is
// held low, and the result path cannot be stalled.
// Reset (arst_n low, asynchronous) clears the pipeline valid bits and loads the
// configuration registers with their defaults.
`default_nettype none

module hsv_shadow_pixel_classifier #(
	parameter int RATIO_FRAC_BITS  = hsvsc_pkg::RATIO_FRAC_BITS_DEF,
	parameter int MARGIN_FRAC_BITS = hsvsc_pkg::MARGIN_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel transaction in
	input  wire logic                              start,
	output logic                                   busy,
	input  wire hsvsc_pkg::pixel_t                 pixel,
	// configuration write port
	input  wire logic                              write_enable,
	input  wire logic [hsvsc_pkg::CFG_INDEX_W-1:0] register_index,
	input  wire logic [hsvsc_pkg::CFG_DATA_W-1:0]  write_data,
	// result transaction out
	output logic                                   strobe,
	output hsvsc_pkg::result_t                     result
);

	// Width for the value-ratio cross products: limit * background value
	// against current value shifted up by the fraction bits.
	localparam int LIM_PROD_W = hsvsc_pkg::RATIO_LIMIT_W + hsvsc_pkg::CH_W;
	localparam int SCALED_W   = hsvsc_pkg::CH_W + RATIO_FRAC_BITS;
	localparam int RPROD_W    = (LIM_PROD_W > SCALED_W) ? LIM_PROD_W : SCALED_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [hsvsc_pkg::RATIO_LIMIT_W-1:0] ratio_low_q;
	logic [hsvsc_pkg::RATIO_LIMIT_W-1:0] ratio_high_q;
	logic [hsvsc_pkg::DIFF_LIMIT_W-1:0]  sat_limit_q;
	logic [hsvsc_pkg::DIFF_LIMIT_W-1:0]  hue_limit_q;
	logic [hsvsc_pkg::MARGIN_W-1:0]      change_margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_low_q     <= hsvsc_pkg::RATIO_LOW_RST;
			ratio_high_q    <= hsvsc_pkg::RATIO_HIGH_RST;
			sat_limit_q     <= hsvsc_pkg::SAT_LIMIT_RST;
			hue_limit_q     <= hsvsc_pkg::HUE_LIMIT_RST;
			change_margin_q <= hsvsc_pkg::CHANGE_MARGIN_RST;
		end else if (write_enable) begin
			// indexes past the last register fall through and are dropped
			unique case (register_index)
				hsvsc_pkg::REG_RATIO_LOW:     ratio_low_q     <= write_data;
				hsvsc_pkg::REG_RATIO_HIGH:    ratio_high_q    <= write_data;
				hsvsc_pkg::REG_SAT_LIMIT:     sat_limit_q     <= write_data[hsvsc_pkg::DIFF_LIMIT_W-1:0];
				hsvsc_pkg::REG_HUE_LIMIT:     hue_limit_q     <= write_data[hsvsc_pkg::DIFF_LIMIT_W-1:0];
				hsvsc_pkg::REG_CHANGE_MARGIN: change_margin_q <= write_data[hsvsc_pkg::MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic              accept;
	logic              valid_s1;
	hsvsc_pkg::pixel_t pixel_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 -> 2: zero substitution, products, difference tests
	// ---------------------------------------------------------------
	logic [hsvsc_pkg::CH_W-1:0] iv, kv, is_n, ks;

	always_comb begin
		iv   = hsvsc_pkg::nz(pixel_s1.pixel_value);
		kv   = hsvsc_pkg::nz(pixel_s1.back_value);
		is_n = hsvsc_pkg::nz(pixel_s1.pixel_saturation);
		ks   = hsvsc_pkg::nz(pixel_s1.back_saturation);
	end

	logic               valid_s2;
	logic               fg_s2;
	logic               sat_ok_s2;
	logic               hue_ok_s2;
	logic [RPROD_W-1:0] scaled_s2;
	logic [RPROD_W-1:0] low_prod_s2;
	logic [RPROD_W-1:0] high_prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		fg_s2        <= pixel_s1.foreground_bit;
		// saturation difference uses the raw channels, hue has no wrap
		sat_ok_s2    <= hsvsc_pkg::absdiff(pixel_s1.pixel_saturation,
		                                   pixel_s1.back_saturation) <= sat_limit_q;
		hue_ok_s2    <= hsvsc_pkg::absdiff(pixel_s1.pixel_hue,
		                                   pixel_s1.back_hue) <= hue_limit_q;
		scaled_s2    <= RPROD_W'(iv) << RATIO_FRAC_BITS;
		low_prod_s2  <= RPROD_W'(ratio_low_q) * RPROD_W'(kv);
		high_prod_s2 <= RPROD_W'(ratio_high_q) * RPROD_W'(kv);
	end

	// Change test: value and saturation ratios against the margin band.
	// Each check holds its products in its own stage-2 register.
	logic value_out;
	logic sat_out;

	hsvsc_band_check #(
		.MARGIN_FRAC_BITS(MARGIN_FRAC_BITS)
	) u_value_band (
		.clk    (clk),
		.num    (iv),
		.den    (kv),
		.margin (change_margin_q),
		.outside(value_out)
	);

	hsvsc_band_check #(
		.MARGIN_FRAC_BITS(MARGIN_FRAC_BITS)
	) u_sat_band (
		.clk    (clk),
		.num    (is_n),
		.den    (ks),
		.margin (change_margin_q),
		.outside(sat_out)
	);

	// ---------------------------------------------------------------
	// Stage 2 -> 3: compares and result register
	// ---------------------------------------------------------------
	logic               in_ratio;
	logic               strobe_q;
	hsvsc_pkg::result_t result_q;

	// both bounds inclusive; low above high lets nothing through
	assign in_ratio = (low_prod_s2 <= scaled_s2) && (scaled_s2 <= high_prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_q.shadow_flag  <= fg_s2 && in_ratio && sat_ok_s2 && hue_ok_s2;
		result_q.changed_flag <= value_out && sat_out;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire
